### rtl/sf_pkg.sv
package sf_pkg;

  // Delay ring and sine table geometry.
  localparam int BUFFER_LEN      = 4096;
  localparam int ADDR_W          = $clog2(BUFFER_LEN);
  localparam int SINE_TABLE_SIZE = 256;
  localparam int SINE_W          = $clog2(SINE_TABLE_SIZE);

  // Fixed field widths.
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int SAMPLE_W  = 16;
  localparam int RING_W    = 18;
  localparam int SINE_DW   = 17;
  localparam int GAIN_W    = 17;
  localparam int OGAIN_W   = 31;
  localparam int FRAC_W    = 8;
  localparam int DELAY_W   = ADDR_W + FRAC_W;

  // Iterative divider: the quotient always fits in DIV_Q_W bits.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 46;
  localparam int DIV_Q_W   = 19;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // Lane datapath widths.
  localparam int X_W    = 19;
  localparam int AX_W   = 18;
  localparam int Y_W    = 36;
  localparam int AY_W   = 35;
  localparam int SQ_W   = 36;
  localparam int P_W    = 37;
  localparam int PSPLIT = 19;
  localparam int ACC_W  = 55;
  localparam int CD_W   = 40;

  localparam int RING_MAX   = 2 ** (RING_W - 1) - 1;
  localparam int RING_MIN   = -(2 ** (RING_W - 1));
  localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

  localparam int MAX_DELAY = (BUFFER_LEN - 1) * (2 ** FRAC_W);

  localparam logic [GAIN_W-1:0]  UNITY      = GAIN_W'(32768);
  localparam logic [13:0]        OUT_GAIN_K = 14'd13518;
  localparam logic [OGAIN_W-1:0] OGAIN_ONE  = OGAIN_W'(64'd1 << 30);
  localparam logic [P_W-1:0]     CLIP_BASE  = P_W'(64'd15 << 30);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LFO_PERIOD = 3'd0,
    REG_CENTER     = 3'd1,
    REG_SWEEP      = 3'd2,
    REG_REGEN      = 3'd3,
    REG_MIX        = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_PHASE_GO,
    T_PHASE_WAIT,
    T_SWEEP,
    T_DELAY,
    T_LANES_GO,
    T_LANES_WAIT,
    T_PUSH
  } top_state_t;

  typedef enum logic [3:0] {
    L_CLEAR,
    L_IDLE,
    L_RD_PREV,
    L_RD_NEXT,
    L_INTERP,
    L_FEEDBK,
    L_MIX,
    L_SQUARE,
    L_PROD_LO,
    L_PROD_HI,
    L_CLIP_GO,
    L_CLIP_WAIT,
    L_OUT_GO,
    L_OUT_WAIT
  } lane_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  tap;
    logic [FRAC_W-1:0]  frac;
    logic [ADDR_W-1:0]  wpos;
    logic [GAIN_W-1:0]  regen;
    logic [GAIN_W-1:0]  mix;
    logic [OGAIN_W-1:0] ogain;
  } sf_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
  } sf_lane_stat_t;

  typedef logic signed [SINE_DW-1:0] sine_lut_t [SINE_TABLE_SIZE];

  // Polynomial sine, one entry per table step, Q2.15 with full scale 32768.
  function automatic sine_lut_t build_sine();
    sine_lut_t t;
    longint p;
    longint z;
    longint zz;
    longint s;
    longint quad;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      p    = (longint'(k) * 65536) / SINE_TABLE_SIZE;
      quad = (p >> 14) & 3;
      z    = p & 16383;
      if (quad == 1 || quad == 3) begin
        z = 16384 - z;
      end
      zz = (z * z) >> 14;
      s  = 10512 - ((zz * 1160) >> 14);
      s  = 25736 - ((zz * s) >> 14);
      s  = ((z * s) >> 14) * 2;
      if (quad >= 2) begin
        s = -s;
      end
      t[k] = SINE_DW'(s);
    end
    return t;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

endpackage

### rtl/sf_div.sv
module sf_div import sf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_Q_W-1:0]   quot
);

  // Restoring division, one quotient bit per cycle, most significant first.
  logic [DIV_NUM_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] dsh_r, dsh_nxt;
  logic [DIV_Q_W-1:0]   q_r, q_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num;
      dsh_nxt = {den, {(DIV_Q_W - 1){1'b0}}};
      q_nxt   = '0;
      cnt_nxt = DIV_CNT_W'(DIV_Q_W);
    end else if (cnt_r != '0) begin
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[DIV_Q_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[DIV_Q_W-2:0], 1'b0};
      end
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### rtl/sf_lane.sv
module sf_lane import sf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  sf_cmd_t                    cmd,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output sf_lane_stat_t              stat,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  logic signed [RING_W-1:0] ring_mem [BUFFER_LEN];
  logic signed [RING_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]        mem_raddr;
  logic [ADDR_W-1:0]        mem_waddr;
  logic                     mem_we;
  logic signed [RING_W-1:0] mem_wdata;

  lane_state_t state_r, state_nxt;
  logic [ADDR_W-1:0]          clr_r, clr_nxt;
  sf_cmd_t                    cmd_r, cmd_nxt;
  logic signed [SAMPLE_W-1:0] in_r, in_nxt;
  logic signed [RING_W-1:0]   prev_r, prev_nxt;
  logic signed [RING_W-1:0]   dly_r, dly_nxt;
  logic                       x_neg_r, x_neg_nxt;
  logic [AX_W-1:0]            ax_r, ax_nxt;
  logic                       y_neg_r, y_neg_nxt;
  logic [AY_W-1:0]            ay_r, ay_nxt;
  logic [SQ_W-1:0]            x2_r, x2_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic signed [SAMPLE_W-1:0] out_r, out_nxt;
  logic                       done_r, done_nxt;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   div_quot;

  logic [ADDR_W-1:0]             ip;
  logic [ADDR_W-1:0]             in2;
  logic signed [RING_W:0]        diff_s;
  logic signed [FRAC_W:0]        frac_s;
  logic signed [RING_W+FRAC_W+1:0] fprod;
  logic signed [RING_W+FRAC_W+2:0] interp_s;
  logic signed [GAIN_W:0]        regen_s;
  logic signed [GAIN_W:0]        mix_s;
  logic signed [RING_W+GAIN_W:0] fbp;
  logic signed [RING_W+GAIN_W:0] fbr;
  logic signed [X_W-1:0]         x_s;
  logic signed [RING_W+GAIN_W:0] yp;
  logic signed [Y_W-1:0]         y_s;
  logic [P_W-1:0]                pfull;
  logic [AX_W+PSPLIT-1:0]        plo_prod;
  logic [AX_W+P_W-PSPLIT-1:0]    phi_prod;
  logic [CD_W-1:0]               cden;
  logic signed [DIV_Q_W:0]       qmag;
  logic signed [DIV_Q_W:0]       clip_s;
  logic signed [DIV_Q_W:0]       outq_s;
  logic signed [RING_W-1:0]      clip_sat;
  logic signed [SAMPLE_W-1:0]    out_sat;

  sf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= ring_mem[mem_raddr];
  end

  // Tap addresses: the older tap is one entry further back when there is a fraction.
  assign ip  = cmd_r.wpos - cmd_r.tap;
  assign in2 = ip - ADDR_W'(cmd_r.frac != '0);

  assign diff_s   = rd_data_r - prev_r;
  assign frac_s   = $signed({1'b0, cmd_r.frac});
  assign fprod    = frac_s * diff_s;
  assign interp_s = ((RING_W+FRAC_W+3)'(prev_r) <<< FRAC_W) + (RING_W+FRAC_W+3)'(fprod)
                  + (RING_W+FRAC_W+3)'(128);

  assign regen_s = $signed({1'b0, cmd_r.regen});
  assign mix_s   = $signed({1'b0, cmd_r.mix});
  assign fbp     = regen_s * dly_r;
  assign fbr     = fbp + (RING_W+GAIN_W+1)'(16384);
  assign x_s     = X_W'(in_r) + X_W'(fbr >>> 15);
  assign yp      = mix_s * dly_r;
  assign y_s     = (Y_W'(in_r) <<< 15) + Y_W'(yp);

  assign pfull    = CLIP_BASE + P_W'(x2_r);
  assign plo_prod = ax_r * pfull[PSPLIT-1:0];
  assign phi_prod = ax_r * pfull[P_W-1:PSPLIT];
  assign cden     = CD_W'(CLIP_BASE) + (CD_W'(x2_r) << 2) + (CD_W'(x2_r) << 1);

  assign qmag   = $signed({1'b0, div_quot});
  assign clip_s = x_neg_r ? -qmag : qmag;
  assign outq_s = y_neg_r ? -qmag : qmag;

  always_comb begin
    if (clip_s > (DIV_Q_W+1)'(RING_MAX)) begin
      clip_sat = RING_W'(RING_MAX);
    end else if (clip_s < (DIV_Q_W+1)'(RING_MIN)) begin
      clip_sat = RING_W'(RING_MIN);
    end else begin
      clip_sat = RING_W'(clip_s);
    end
    if (outq_s > (DIV_Q_W+1)'(SAMPLE_MAX)) begin
      out_sat = SAMPLE_W'(SAMPLE_MAX);
    end else if (outq_s < (DIV_Q_W+1)'(SAMPLE_MIN)) begin
      out_sat = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      out_sat = SAMPLE_W'(outq_s);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = L_IDLE;
        end
      end
      L_IDLE: begin
        if (start) begin
          state_nxt = L_RD_PREV;
        end
      end
      L_RD_PREV:   state_nxt = L_RD_NEXT;
      L_RD_NEXT:   state_nxt = L_INTERP;
      L_INTERP:    state_nxt = L_FEEDBK;
      L_FEEDBK:    state_nxt = L_MIX;
      L_MIX:       state_nxt = L_SQUARE;
      L_SQUARE:    state_nxt = L_PROD_LO;
      L_PROD_LO:   state_nxt = L_PROD_HI;
      L_PROD_HI:   state_nxt = L_CLIP_GO;
      L_CLIP_GO:   state_nxt = L_CLIP_WAIT;
      L_CLIP_WAIT: begin
        if (div_done) begin
          state_nxt = L_OUT_GO;
        end
      end
      L_OUT_GO:    state_nxt = L_OUT_WAIT;
      L_OUT_WAIT: begin
        if (div_done) begin
          state_nxt = L_IDLE;
        end
      end
      default:     state_nxt = L_CLEAR;
    endcase
  end

  always_comb begin
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    in_nxt    = in_r;
    prev_nxt  = prev_r;
    dly_nxt   = dly_r;
    x_neg_nxt = x_neg_r;
    ax_nxt    = ax_r;
    y_neg_nxt = y_neg_r;
    ay_nxt    = ay_r;
    x2_nxt    = x2_r;
    acc_nxt   = acc_r;
    out_nxt   = out_r;
    done_nxt  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cmd_r.wpos;
    mem_wdata = clip_sat;
    mem_raddr = ip;
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(acc_r) + DIV_NUM_W'(cden >> 1);
    div_den   = DIV_DEN_W'(cden);
    case (state_r)
      L_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      L_IDLE: begin
        if (start) begin
          cmd_nxt = cmd;
          in_nxt  = sample_in;
        end
      end
      L_RD_NEXT: begin
        mem_raddr = in2;
        prev_nxt  = rd_data_r;
      end
      L_INTERP: begin
        dly_nxt = interp_s[FRAC_W +: RING_W];
      end
      L_FEEDBK: begin
        x_neg_nxt = x_s[X_W-1];
        ax_nxt    = x_s[X_W-1] ? AX_W'(-x_s) : AX_W'(x_s);
      end
      L_MIX: begin
        y_neg_nxt = y_s[Y_W-1];
        ay_nxt    = y_s[Y_W-1] ? AY_W'(-y_s) : AY_W'(y_s);
      end
      L_SQUARE: begin
        x2_nxt = ax_r * ax_r;
      end
      L_PROD_LO: begin
        acc_nxt = ACC_W'(plo_prod);
      end
      L_PROD_HI: begin
        acc_nxt = acc_r + (ACC_W'(phi_prod) << PSPLIT);
      end
      L_CLIP_GO: begin
        div_start = 1'b1;
      end
      L_CLIP_WAIT: begin
        mem_we = div_done;
      end
      L_OUT_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({ay_r, 15'b0}) + DIV_NUM_W'(cmd_r.ogain >> 1);
        div_den   = DIV_DEN_W'(cmd_r.ogain);
      end
      L_OUT_WAIT: begin
        if (div_done) begin
          out_nxt  = out_sat;
          done_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_CLEAR;
      clr_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    in_r    <= in_nxt;
    prev_r  <= prev_nxt;
    dly_r   <= dly_nxt;
    x_neg_r <= x_neg_nxt;
    ax_r    <= ax_nxt;
    y_neg_r <= y_neg_nxt;
    ay_r    <= ay_nxt;
    x2_r    <= x2_nxt;
    acc_r   <= acc_nxt;
    out_r   <= out_nxt;
  end

  assign stat.ready = (state_r == L_IDLE);
  assign stat.done  = done_r;
  assign sample_out = out_r;

endmodule

### rtl/stereo_flanger.sv
// Stereo flanger. Each input beat carries one stereo frame of Q1.15 samples and
// produces exactly one output beat with the flanged frame. A frame passes through
// three 19-step restoring divisions: one for the LFO phase and then, in both
// channel lanes at once, one for the soft clip of the feedback and one for the
// output gain correction.
// The block works on one frame at a time, but a finished frame waits in the output
// register, so the next input beat is taken while the previous result is still
// stalled. After reset each lane clears its 4096-entry delay ring, one entry per
// cycle, so no input beat is taken until the clearing pass ends; configuration
// writes are taken at any time and should only be issued while the block is idle.
module stereo_flanger import sf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_left_in,
  input  logic signed [SAMPLE_W-1:0] in_right_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  // Configuration registers.
  logic [CFG_W-1:0] period_r;
  logic [CFG_W-1:0] center_r;
  logic [CFG_W-1:0] sweep_r;
  logic [15:0]      regen_r;
  logic [15:0]      mix_r;

  top_state_t state_r, state_nxt;
  logic [CFG_W-1:0]           lfo_r, lfo_nxt;
  logic [ADDR_W-1:0]          wpos_r, wpos_nxt;
  logic signed [SAMPLE_W-1:0] left_r, left_nxt;
  logic signed [SAMPLE_W-1:0] right_r, right_nxt;
  logic signed [SINE_DW-1:0]  sine_r, sine_nxt;
  logic signed [CFG_W+SINE_DW:0] sprod_r, sprod_nxt;
  sf_cmd_t                    cmd_r, cmd_nxt;
  logic                       ldone_r, ldone_nxt;
  logic                       rdone_r, rdone_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_left_r, out_left_nxt;
  logic signed [SAMPLE_W-1:0] out_right_r, out_right_nxt;

  logic                 in_beat;
  logic                 out_free;
  logic [CFG_W-1:0]     period_eff;
  logic [CFG_W-1:0]     lfo_inc;
  logic [GAIN_W-1:0]    regen_eff;
  logic [GAIN_W-1:0]    mix_eff;
  logic signed [CFG_W:0] sw_s;
  logic signed [39:0]   sum_d;
  logic signed [25:0]   delay_s;
  logic [DELAY_W-1:0]   delay_sat;
  logic [OGAIN_W-1:0]   ogain_prod;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   div_quot;

  logic                       lanes_start;
  sf_lane_stat_t              lstat;
  sf_lane_stat_t              rstat;
  logic signed [SAMPLE_W-1:0] lane_left;
  logic signed [SAMPLE_W-1:0] lane_right;

  // The phase divider turns the frame counter into a sine table index.
  sf_div u_phase_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  sf_lane u_lane_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (lanes_start),
    .cmd        (cmd_r),
    .sample_in  (left_r),
    .stat       (lstat),
    .sample_out (lane_left)
  );

  sf_lane u_lane_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (lanes_start),
    .cmd        (cmd_r),
    .sample_in  (right_r),
    .stat       (rstat),
    .sample_out (lane_right)
  );

  assign in_stall = !(state_r == T_IDLE && lstat.ready && rstat.ready);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // A period of zero behaves as a period of one; gains above one clamp to one.
  assign period_eff = (period_r == '0) ? CFG_W'(1) : period_r;
  assign lfo_inc    = lfo_r + 1'b1;
  assign regen_eff  = ({1'b0, regen_r} > UNITY) ? UNITY : {1'b0, regen_r};
  assign mix_eff    = ({1'b0, mix_r} > UNITY) ? UNITY : {1'b0, mix_r};

  // Delay is the center plus half the sweep times the sine, in 1/256 frames.
  assign sw_s    = $signed({1'b0, sweep_r});
  assign sum_d   = 40'(sprod_r) + $signed(40'({sweep_r, 16'b0})) + 40'(32768);
  assign delay_s = 26'(sum_d >>> 16) + 26'($signed({1'b0, center_r}))
                 - 26'($signed({1'b0, sweep_r}));

  always_comb begin
    if (delay_s[25]) begin
      delay_sat = '0;
    end else if (delay_s > 26'(MAX_DELAY)) begin
      delay_sat = DELAY_W'(MAX_DELAY);
    end else begin
      delay_sat = DELAY_W'(delay_s);
    end
  end

  // Output correction gain, Q30: one plus 0.41253662 times the mix.
  assign ogain_prod = mix_eff * OUT_GAIN_K;

  assign lanes_start = (state_r == T_LANES_GO);
  assign div_start   = (state_r == T_PHASE_GO);
  assign div_num     = DIV_NUM_W'({lfo_r, {SINE_W{1'b0}}});
  assign div_den     = DIV_DEN_W'(period_eff);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (in_beat) begin
          state_nxt = T_PHASE_GO;
        end
      end
      T_PHASE_GO:   state_nxt = T_PHASE_WAIT;
      T_PHASE_WAIT: begin
        if (div_done) begin
          state_nxt = T_SWEEP;
        end
      end
      T_SWEEP:      state_nxt = T_DELAY;
      T_DELAY:      state_nxt = T_LANES_GO;
      T_LANES_GO:   state_nxt = T_LANES_WAIT;
      T_LANES_WAIT: begin
        if ((ldone_r || lstat.done) && (rdone_r || rstat.done)) begin
          state_nxt = T_PUSH;
        end
      end
      T_PUSH: begin
        if (out_free) begin
          state_nxt = T_IDLE;
        end
      end
      default:      state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    lfo_nxt       = lfo_r;
    wpos_nxt      = wpos_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    sine_nxt      = sine_r;
    sprod_nxt     = sprod_r;
    cmd_nxt       = cmd_r;
    ldone_nxt     = ldone_r || lstat.done;
    rdone_nxt     = rdone_r || rstat.done;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      T_IDLE: begin
        if (in_beat) begin
          // The counter steps first and wraps once it reaches the period.
          lfo_nxt   = (lfo_inc >= period_eff) ? '0 : lfo_inc;
          left_nxt  = in_left_in;
          right_nxt = in_right_in;
        end
      end
      T_PHASE_WAIT: begin
        if (div_done) begin
          sine_nxt = SINE_LUT[div_quot[SINE_W-1:0]];
        end
      end
      T_SWEEP: begin
        sprod_nxt = sw_s * sine_r;
      end
      T_DELAY: begin
        cmd_nxt.tap   = delay_sat[FRAC_W +: ADDR_W];
        cmd_nxt.frac  = delay_sat[FRAC_W-1:0];
        cmd_nxt.wpos  = wpos_r;
        cmd_nxt.regen = regen_eff;
        cmd_nxt.mix   = mix_eff;
        cmd_nxt.ogain = OGAIN_ONE + ogain_prod;
      end
      T_LANES_GO: begin
        ldone_nxt = 1'b0;
        rdone_nxt = 1'b0;
      end
      T_PUSH: begin
        if (out_free) begin
          out_left_nxt  = lane_left;
          out_right_nxt = lane_right;
          out_valid_nxt = 1'b1;
          wpos_nxt      = wpos_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      lfo_r       <= '0;
      wpos_r      <= '0;
      ldone_r     <= 1'b0;
      rdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lfo_r       <= lfo_nxt;
      wpos_r      <= wpos_nxt;
      ldone_r     <= ldone_nxt;
      rdone_r     <= rdone_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    sine_r      <= sine_nxt;
    sprod_r     <= sprod_nxt;
    cmd_r       <= cmd_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  // Register writes; indexes outside the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= CFG_W'(48000);
      center_r <= CFG_W'(40960);
      sweep_r  <= CFG_W'(81920);
      regen_r  <= 16'd8192;
      mix_r    <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LFO_PERIOD: period_r <= cfg_data;
        REG_CENTER:     center_r <= cfg_data;
        REG_SWEEP:      sweep_r  <= cfg_data;
        REG_REGEN:      regen_r  <= cfg_data[15:0];
        REG_MIX:        mix_r    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

endmodule

### rtl/sf_checker.sv
module sf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_left_out,
  input logic [15:0] out_right_out
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_out) && $stable(out_right_out))
    else $error("stalled output beat changed");

  // Reset starts the ring clearing pass, so input is held off right after it.
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // One frame at a time: an accepted beat closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second frame taken while one is in flight");

  // A result never appears in the cycle right after a frame is taken.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind stereo_flanger sf_checker u_sf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_left_out  (out_left_out),
  .out_right_out (out_right_out)
);
